>>> sv/gbd_pkg.sv
package gbd_pkg;

    localparam int OFFSET_BITS = 24;

    localparam logic [1:0] KIND_SCREEN = 2'd0;
    localparam logic [1:0] KIND_FRAME  = 2'd1;
    localparam logic [1:0] KIND_OK     = 2'd2;
    localparam logic [1:0] KIND_FAIL   = 2'd3;

    localparam logic [7:0] INTRO_EXT   = 8'h21;
    localparam logic [7:0] LABEL_GCE   = 8'hF9;
    localparam logic [7:0] INTRO_IMAGE = 8'h2C;
    localparam logic [7:0] LABEL_COMM  = 8'hFE;
    localparam logic [7:0] LABEL_APP   = 8'hFF;
    localparam logic [7:0] LABEL_TEXT  = 8'h01;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } gbd_in_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] x_offset;
        logic [15:0] y_offset;
        logic [15:0] delay;
        logic [2:0]  disposal;
        logic [23:0] bg_color;
        logic [23:0] frame_start;
        logic [23:0] frame_length;
        logic        last_of_run;
    } gbd_out_t;

    // results of one byte: up to two records
    typedef struct packed {
        logic     valid0;
        logic     valid1;
        gbd_out_t rec0;
        gbd_out_t rec1;
    } gbd_pair_t;

    function automatic gbd_out_t gbd_end_rec(input logic fail);
        gbd_out_t r;
        r = '0;
        r.record_kind = fail ? KIND_FAIL : KIND_OK;
        return r;
    endfunction

endpackage

>>> sv/gbd_parser.sv
module gbd_parser
    import gbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  gbd_in_t   item,
    output gbd_pair_t res
);

    typedef enum logic [3:0] {
        PH_HDR, PH_LSD, PH_GCT, PH_BLOCK, PH_LABEL, PH_LEN, PH_DATA,
        PH_DESC, PH_LCT, PH_LZW, PH_DONE
    } phase_t;

    typedef enum logic [1:0] {BK_EXT, BK_GCE, BK_TEXT, BK_IMAGE} block_t;

    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [9:0]             fc_reg, fc_next;
    logic [7:0]             sub_reg, sub_next;
    logic [31:0]            cap_reg, cap_next;
    logic [7:0]             bgi_reg, bgi_next;
    logic [23:0]            bgc_reg, bgc_next;
    logic [15:0]            dly_reg, dly_next;
    logic [2:0]             disp_reg, disp_next;
    logic                   grp_reg, grp_next;
    logic [OFFSET_BITS-1:0] gst_reg, gst_next;
    logic [63:0]            geo_reg, geo_next;
    logic [OFFSET_BITS-1:0] bst_reg, bst_next;
    block_t                 bk_reg, bk_next;
    logic [9:0]             tbl_reg, tbl_next;
    logic [7:0]             flags_reg, flags_next;
    logic                   take_reg, take_next;
    // colour table position as entry index and byte within entry
    logic [7:0]             ent_reg, ent_next;
    logic [1:0]             sub3_reg, sub3_next;

    logic [7:0]             b;
    logic                   ok, early;
    logic [OFFSET_BITS-1:0] st, flen;
    logic [9:0]             fc_inc;
    gbd_out_t               scr, frm;

    always_comb
    begin
        b = item.data_byte;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        fc_next    = fc_reg;
        sub_next   = sub_reg;
        cap_next   = cap_reg;
        bgi_next   = bgi_reg;
        bgc_next   = bgc_reg;
        dly_next   = dly_reg;
        disp_next  = disp_reg;
        grp_next   = grp_reg;
        gst_next   = gst_reg;
        geo_next   = geo_reg;
        bst_next   = bst_reg;
        bk_next    = bk_reg;
        tbl_next   = tbl_reg;
        flags_next = flags_reg;
        take_next  = take_reg;
        ent_next   = ent_reg;
        sub3_next  = sub3_reg;
        res        = '0;
        ok         = 1'b0;
        early      = 1'b0;
        fc_inc     = fc_reg + 10'd1;
        st         = grp_reg ? gst_reg : bst_reg;
        flen       = pos_reg - st + {{(OFFSET_BITS-1){1'b0}}, 1'b1};

        scr = '0;
        scr.record_kind = KIND_SCREEN;
        scr.width       = cap_reg[15:0];
        scr.height      = cap_reg[31:16];
        scr.bg_color    = bgc_reg;

        frm = '0;
        frm.record_kind  = KIND_FRAME;
        frm.width        = geo_reg[47:32];
        frm.height       = geo_reg[63:48];
        frm.x_offset     = geo_reg[15:0];
        frm.y_offset     = geo_reg[31:16];
        frm.delay        = grp_reg ? dly_reg : 16'hFFFF;
        frm.disposal     = grp_reg ? disp_reg : 3'd0;
        frm.bg_color     = bgc_reg;
        frm.frame_start  = 24'(st);
        frm.frame_length = 24'(flen);

        case (phase_reg)
            PH_HDR:
            begin
                case (fc_reg[2:0])
                    3'd0:    ok = (b == "G");
                    3'd1:    ok = (b == "I");
                    3'd2:    ok = (b == "F");
                    3'd3:    ok = (b == "8");
                    3'd4:    ok = (b == "7") || (b == "9");
                    default: ok = (b == "a");
                endcase
                if (!ok)
                begin
                    res.valid0 = 1'b1;
                    res.rec0   = gbd_end_rec(1'b1);
                    phase_next = PH_DONE;
                end
                else if (fc_reg >= 10'd5)
                begin
                    fc_next    = '0;
                    phase_next = PH_LSD;
                end
                else
                    fc_next = fc_inc;
            end
            PH_LSD:
            begin
                case (fc_reg[2:0])
                    3'd0:    cap_next[7:0]   = b;
                    3'd1:    cap_next[15:8]  = b;
                    3'd2:    cap_next[23:16] = b;
                    3'd3:    cap_next[31:24] = b;
                    3'd4:    flags_next      = b;
                    3'd5:    bgi_next        = b;
                    default: ;
                endcase
                if (fc_reg >= 10'd6)
                begin
                    fc_next = '0;
                    if (flags_reg[7])
                    begin
                        tbl_next   = 10'(10'd3 << ({1'b0, flags_reg[2:0]} + 4'd1));
                        ent_next   = '0;
                        sub3_next  = '0;
                        phase_next = PH_GCT;
                    end
                    else
                    begin
                        res.valid0 = 1'b1;
                        res.rec0   = scr;
                        phase_next = PH_BLOCK;
                    end
                end
                else
                    fc_next = fc_inc;
            end
            PH_GCT:
            begin
                if (ent_reg == bgi_reg)
                begin
                    case (sub3_reg)
                        2'd0:    bgc_next[23:16] = b;
                        2'd1:    bgc_next[15:8]  = b;
                        default: bgc_next[7:0]   = b;
                    endcase
                end
                if (sub3_reg == 2'd2)
                begin
                    sub3_next = '0;
                    ent_next  = ent_reg + 8'd1;
                end
                else
                    sub3_next = sub3_reg + 2'd1;
                fc_next = fc_inc;
                if (fc_inc >= tbl_reg)
                begin
                    fc_next    = '0;
                    res.valid0 = 1'b1;
                    res.rec0   = scr;
                    res.rec0.bg_color = (ent_reg == bgi_reg && sub3_reg == 2'd2)
                                        ? {bgc_reg[23:8], b} : bgc_reg;
                    phase_next = PH_BLOCK;
                end
            end
            PH_BLOCK:
            begin
                bst_next = pos_reg;
                if (b == INTRO_IMAGE)
                begin
                    geo_next   = '0;
                    fc_next    = 10'd1;
                    phase_next = PH_DESC;
                end
                else if (b == INTRO_EXT)
                    phase_next = PH_LABEL;
                else
                begin
                    res.valid0 = 1'b1;
                    res.rec0   = gbd_end_rec(grp_reg);
                    phase_next = PH_DONE;
                end
            end
            PH_LABEL:
            begin
                fc_next   = 10'd2;
                take_next = 1'b0;
                if (b == LABEL_GCE)
                begin
                    bk_next = BK_GCE;
                    if (!grp_reg)
                    begin
                        grp_next  = 1'b1;
                        gst_next  = bst_reg;
                        dly_next  = 16'hFFFF;
                        disp_next = '0;
                        take_next = 1'b1;
                    end
                    phase_next = PH_LEN;
                end
                else if (b == LABEL_TEXT)
                begin
                    bk_next    = BK_TEXT;
                    phase_next = PH_LEN;
                end
                else if (b == LABEL_COMM || b == LABEL_APP)
                begin
                    bk_next    = BK_EXT;
                    phase_next = PH_LEN;
                end
                else
                begin
                    res.valid0 = 1'b1;
                    res.rec0   = gbd_end_rec(grp_reg);
                    phase_next = PH_DONE;
                end
            end
            PH_LEN, PH_DATA:
            begin
                if (bk_reg == BK_GCE && take_reg)
                begin
                    if (fc_reg == 10'd3)
                        disp_next = b[4:2];
                    else if (fc_reg == 10'd4)
                        dly_next[7:0] = b;
                    else if (fc_reg == 10'd5)
                        dly_next[15:8] = b;
                end
                if (fc_reg != 10'd1023)
                    fc_next = fc_inc;
                if (phase_reg == PH_DATA)
                begin
                    sub_next = sub_reg - 8'd1;
                    if (sub_reg == 8'd1)
                        phase_next = PH_LEN;
                end
                else if (b != 8'd0)
                begin
                    sub_next   = b;
                    phase_next = PH_DATA;
                end
                else
                begin
                    if (bk_reg == BK_IMAGE)
                    begin
                        res.valid0 = 1'b1;
                        res.rec0   = frm;
                        grp_next   = 1'b0;
                    end
                    else if (bk_reg == BK_TEXT)
                        grp_next = 1'b0;
                    phase_next = PH_BLOCK;
                end
            end
            PH_DESC:
            begin
                if (fc_reg < 10'd9)
                begin
                    case (fc_reg[3:0])
                        4'd1:    geo_next[7:0]   = b;
                        4'd2:    geo_next[15:8]  = b;
                        4'd3:    geo_next[23:16] = b;
                        4'd4:    geo_next[31:24] = b;
                        4'd5:    geo_next[39:32] = b;
                        4'd6:    geo_next[47:40] = b;
                        4'd7:    geo_next[55:48] = b;
                        default: geo_next[63:56] = b;
                    endcase
                    fc_next = fc_inc;
                end
                else
                begin
                    fc_next = '0;
                    if (b[7])
                    begin
                        tbl_next   = 10'(10'd3 << ({1'b0, b[2:0]} + 4'd1));
                        phase_next = PH_LCT;
                    end
                    else
                        phase_next = PH_LZW;
                end
            end
            PH_LCT:
            begin
                fc_next = fc_inc;
                if (fc_inc >= tbl_reg)
                begin
                    fc_next    = '0;
                    phase_next = PH_LZW;
                end
            end
            PH_LZW:
            begin
                bk_next    = BK_IMAGE;
                take_next  = 1'b0;
                fc_next    = '0;
                phase_next = PH_LEN;
            end
            default: ;
        endcase

        if (item.final_byte)
        begin
            if (phase_next != PH_DONE)
            begin
                early = (phase_next == PH_HDR) || (phase_next == PH_LSD)
                        || (phase_next == PH_GCT);
                if (res.valid0)
                begin
                    res.valid1 = 1'b1;
                    res.rec1   = gbd_end_rec(early || grp_next);
                end
                else
                begin
                    res.valid0 = 1'b1;
                    res.rec0   = gbd_end_rec(early || grp_next);
                end
            end
            phase_next = PH_HDR;
            pos_next   = '0;
            fc_next    = '0;
            sub_next   = '0;
            cap_next   = '0;
            bgi_next   = '0;
            bgc_next   = 24'hFFFFFF;
            dly_next   = 16'hFFFF;
            disp_next  = '0;
            grp_next   = 1'b0;
            gst_next   = '0;
            geo_next   = '0;
            bst_next   = '0;
            bk_next    = BK_EXT;
            tbl_next   = '0;
            flags_next = '0;
            take_next  = 1'b0;
            ent_next   = '0;
            sub3_next  = '0;
        end
        else
            pos_next = pos_reg + {{(OFFSET_BITS-1){1'b0}}, 1'b1};

        if (res.valid1)
            res.rec1.last_of_run = 1'b1;
        else
            res.rec0.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            pos_reg   <= '0;
            fc_reg    <= '0;
            sub_reg   <= '0;
            cap_reg   <= '0;
            bgi_reg   <= '0;
            bgc_reg   <= 24'hFFFFFF;
            dly_reg   <= 16'hFFFF;
            disp_reg  <= '0;
            grp_reg   <= 1'b0;
            gst_reg   <= '0;
            geo_reg   <= '0;
            bst_reg   <= '0;
            bk_reg    <= BK_EXT;
            tbl_reg   <= '0;
            flags_reg <= '0;
            take_reg  <= 1'b0;
            ent_reg   <= '0;
            sub3_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            fc_reg    <= fc_next;
            sub_reg   <= sub_next;
            cap_reg   <= cap_next;
            bgi_reg   <= bgi_next;
            bgc_reg   <= bgc_next;
            dly_reg   <= dly_next;
            disp_reg  <= disp_next;
            grp_reg   <= grp_next;
            gst_reg   <= gst_next;
            geo_reg   <= geo_next;
            bst_reg   <= bst_next;
            bk_reg    <= bk_next;
            tbl_reg   <= tbl_next;
            flags_reg <= flags_next;
            take_reg  <= take_next;
            ent_reg   <= ent_next;
            sub3_reg  <= sub3_next;
        end
    end

endmodule

>>> sv/gbd_out_queue.sv
module gbd_out_queue
    import gbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  gbd_pair_t pair,
    output logic      can_take,
    output logic      valid,
    input  logic      ready,
    output gbd_out_t  result
);

    // four-entry queue; takes a byte's records when two slots are free
    logic [1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;
    gbd_out_t   q_reg [4];
    logic       pop;
    logic [1:0] wp1;

    assign pop      = valid && ready;
    assign valid    = (cnt_reg != 3'd0);
    assign result   = q_reg[rp_reg];
    assign can_take = (cnt_reg <= 3'd2);
    assign wp1      = wp_reg + 2'd1;

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (pop)
        begin
            rp_next  = rp_reg + 2'd1;
            cnt_next = cnt_next - 3'd1;
        end
        if (push && pair.valid0)
        begin
            if (pair.valid1)
            begin
                wp_next  = wp_reg + 2'd2;
                cnt_next = cnt_next + 3'd2;
            end
            else
            begin
                wp_next  = wp1;
                cnt_next = cnt_next + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && pair.valid0)
        begin
            q_reg[wp_reg] <= pair.rec0;
            if (pair.valid1)
                q_reg[wp1] <= pair.rec1;
        end
    end

endmodule

>>> sv/gif_block_deframer_top.sv
// a record is registered in the result queue when the byte that causes it is taken
// throughput: one byte per cycle while the four-entry result queue has two free slots
// reset: rst_n asynchronous, active low; parser returns to the header phase, queue empties
// the parser also returns to its reset state after every final byte
module gif_block_deframer_top
    import gbd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  gbd_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output gbd_out_t out_data
);

    gbd_pair_t pair;
    logic      step;

    assign step = in_valid && in_ready;

    gbd_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_data),
        .res   (pair)
    );

    gbd_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (step),
        .pair     (pair),
        .can_take (in_ready),
        .valid    (out_valid),
        .ready    (out_ready),
        .result   (out_data)
    );

endmodule
